// ----- sv/delimited_text_parser_macros.svh -----
// Assertion macros for the delimited text parser.
// DTP_ASSERT checks outside reset, DTP_ASSERT_RST also checks while reset is applied.
`ifndef DELIMITED_TEXT_PARSER_MACROS_SVH
`define DELIMITED_TEXT_PARSER_MACROS_SVH

`ifndef SYNTH
`define DTP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("delimited_text_parser: assertion failed");
`define DTP_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("delimited_text_parser: assertion failed during reset");
`else
`define DTP_ASSERT(lbl, clk, rst_n, prop)
`define DTP_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ----- sv/dtp_pkg.sv -----
`timescale 1ns / 1ps

package dtp_pkg;

    localparam int CHAR_W     = 16;
    localparam int APB_ADDR_W = 1;
    localparam int APB_DATA_W = 32;

    localparam logic [CHAR_W-1:0] BOM_UNIT      = 16'hfeff;
    localparam logic [CHAR_W-1:0] QUOTE_UNIT    = 16'h0022;
    localparam logic [CHAR_W-1:0] CR_UNIT       = 16'h000d;
    localparam logic [CHAR_W-1:0] LF_UNIT       = 16'h000a;
    localparam logic [CHAR_W-1:0] DELIMITER_RST = 16'd44;

    localparam logic [APB_ADDR_W-1:0] REG_DELIMITER = 1'b0;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_QUOTE    = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED = 2'd2;

    typedef enum logic [2:0] {
        MODE_UNQUOTED      = 3'd0,
        MODE_QUOTED        = 3'd1,
        MODE_QUOTE_PENDING = 3'd2,
        MODE_CR_PENDING    = 3'd3,
        MODE_ERROR         = 3'd4
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  cell_is_empty;
        logic  quote_was_closed;
        logic  row_has_cells;
        logic  first_unit;
    } parse_state_t;

    typedef struct packed {
        logic              stream_done;
        logic [1:0]        error_code;
        logic              row_end;
        logic              cell_end;
        logic [CHAR_W-1:0] data_char;
        logic              data_valid;
    } result_t;

endpackage

// ----- sv/delimited_text_parser.sv -----
`timescale 1ns / 1ps

// Streaming parser for delimited text tables: one UTF-16 code unit in, one
// result out per item, at a sustained rate of one item per clock cycle while
// m_tready stays high. An item passes through an input register and then a
// result register, from which its result is offered on the master side; it
// moves on into the result register once that slot is empty or being taken.
// All parsing for an item is done in the single step between those two
// registers. s_tready follows m_tready combinationally when both registers
// are full. The delimiter is set through the APB port at address 0 and must
// only be written while no items are in flight; end of text (s_tlast) resets
// parsing but keeps the delimiter.
module delimited_text_parser
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] char_code
    input  logic                                s_tlast,   // end_of_text

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // [15:0] data_char
    // [0] data_valid, [1] cell_end, [2] row_end, [4:3] error_code
    output logic [4:0]                          m_tuser,
    output logic                                m_tlast,   // stream_done

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dtp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dtp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dtp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

`include "delimited_text_parser_macros.svh"

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic [dtp_pkg::CHAR_W-1:0] in_char_reg;
    logic                       in_eot_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    dtp_pkg::result_t           out_res_reg;
    dtp_pkg::result_t           step_res;
    dtp_pkg::parse_state_t      parse_state;
    logic [dtp_pkg::CHAR_W-1:0] delimiter;
    logic                       advance;
    logic                       in_take;

    dtp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .delimiter (delimiter)
    );

    dtp_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .delimiter   (delimiter),
        .result      (step_res),
        .state       (parse_state)
    );

    // Move the held request into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_tdata[dtp_pkg::CHAR_W-1:0];
            in_eot_reg  <= s_tlast;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.data_char;
    assign m_tuser  = {out_res_reg.error_code, out_res_reg.row_end,
                       out_res_reg.cell_end, out_res_reg.data_valid};
    assign m_tlast  = out_res_reg.stream_done;

    `DTP_ASSERT(a_unclosed_only_at_end, clk, rst_n, (out_valid_reg && (out_res_reg.error_code == dtp_pkg::ERR_UNCLOSED)) |-> out_res_reg.stream_done)
    `DTP_ASSERT(a_row_end_has_cell_end, clk, rst_n, (out_valid_reg && out_res_reg.row_end) |-> out_res_reg.cell_end)
    `DTP_ASSERT(a_eot_clears_parse, clk, rst_n, (advance && in_eot_reg) |=> ((parse_state.mode == dtp_pkg::MODE_UNQUOTED) && parse_state.first_unit && parse_state.cell_is_empty && !parse_state.row_has_cells))
    `DTP_ASSERT_RST(a_no_result_in_reset, clk, !rst_n |-> !m_tvalid)

endmodule

// ----- sv/dtp_cfg.sv -----
`timescale 1ns / 1ps

module dtp_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dtp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dtp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dtp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [dtp_pkg::CHAR_W-1:0]          delimiter
);

    logic [dtp_pkg::CHAR_W-1:0] delimiter_reg;
    logic [dtp_pkg::CHAR_W-1:0] delimiter_next;
    logic                       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == dtp_pkg::REG_DELIMITER);

    always_comb
    begin
        delimiter_next = delimiter_reg;
        if (wr_en)
        begin
            delimiter_next = pwdata[dtp_pkg::CHAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= dtp_pkg::DELIMITER_RST;
        end
        else
        begin
            delimiter_reg <= delimiter_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == dtp_pkg::REG_DELIMITER)
        begin
            prdata = {{(dtp_pkg::APB_DATA_W-dtp_pkg::CHAR_W){1'b0}}, delimiter_reg};
        end
    end

    assign delimiter = delimiter_reg;

endmodule

// ----- sv/dtp_core.sv -----
`timescale 1ns / 1ps

module dtp_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [dtp_pkg::CHAR_W-1:0]  char_code,
    input  logic                        end_of_text,
    input  logic [dtp_pkg::CHAR_W-1:0]  delimiter,
    output dtp_pkg::result_t            result,
    output dtp_pkg::parse_state_t       state
);

    dtp_pkg::parse_state_t state_reg;
    dtp_pkg::parse_state_t state_next;
    dtp_pkg::mode_t        mode_next;
    dtp_pkg::mode_t        u_mode;

    logic is_delim;
    logic is_cr;
    logic is_lf;
    logic is_quote;
    logic is_sep;
    logic skip_bom;
    logic qwc_eff;
    logic open_quote;
    logic bad_quote;

    // Unit classification, shared by the mode and the output logic
    assign is_delim   = (char_code == delimiter);
    assign is_cr      = (char_code == dtp_pkg::CR_UNIT);
    assign is_lf      = (char_code == dtp_pkg::LF_UNIT);
    assign is_quote   = (char_code == dtp_pkg::QUOTE_UNIT);
    assign is_sep     = is_delim || is_cr || is_lf;
    assign skip_bom   = state_reg.first_unit && (char_code == dtp_pkg::BOM_UNIT);
    // A pending quote followed by anything but a quote closes the cell
    assign qwc_eff    = state_reg.quote_was_closed ||
                        (state_reg.mode == dtp_pkg::MODE_QUOTE_PENDING);
    assign open_quote = is_quote && state_reg.cell_is_empty && !qwc_eff;
    assign bad_quote  = qwc_eff || is_quote;

    // Mode after handling the unit as plain unquoted text
    always_comb
    begin
        if (is_sep)
        begin
            u_mode = (!is_delim && is_cr) ? dtp_pkg::MODE_CR_PENDING
                                          : dtp_pkg::MODE_UNQUOTED;
        end
        else if (open_quote)
        begin
            u_mode = dtp_pkg::MODE_QUOTED;
        end
        else if (bad_quote)
        begin
            u_mode = dtp_pkg::MODE_ERROR;
        end
        else
        begin
            u_mode = dtp_pkg::MODE_UNQUOTED;
        end
    end

    // Next mode
    always_comb
    begin
        mode_next = state_reg.mode;
        if (end_of_text)
        begin
            mode_next = dtp_pkg::MODE_UNQUOTED;
        end
        else if (state_reg.mode == dtp_pkg::MODE_ERROR)
        begin
            mode_next = dtp_pkg::MODE_ERROR;
        end
        else if (!skip_bom)
        begin
            case (state_reg.mode)
                dtp_pkg::MODE_QUOTED:
                begin
                    mode_next = is_quote ? dtp_pkg::MODE_QUOTE_PENDING
                                         : dtp_pkg::MODE_QUOTED;
                end
                dtp_pkg::MODE_QUOTE_PENDING:
                begin
                    mode_next = is_quote ? dtp_pkg::MODE_QUOTED : u_mode;
                end
                dtp_pkg::MODE_CR_PENDING:
                begin
                    mode_next = is_lf ? dtp_pkg::MODE_UNQUOTED : u_mode;
                end
                default:
                begin
                    mode_next = u_mode;
                end
            endcase
        end
    end

    // Result and cell/row flags
    always_comb
    begin
        logic take_u;
        take_u = 1'b0;
        result = '0;
        state_next = state_reg;
        state_next.mode = mode_next;

        if (end_of_text)
        begin
            result.stream_done = 1'b1;
            case (state_reg.mode)
                dtp_pkg::MODE_ERROR:
                begin
                    result.error_code = dtp_pkg::ERR_QUOTE;
                end
                dtp_pkg::MODE_QUOTED:
                begin
                    result.error_code = dtp_pkg::ERR_UNCLOSED;
                end
                default:
                begin
                    // Flush the last row unless it is a lone bare empty cell
                    if (state_reg.row_has_cells || !state_reg.cell_is_empty || qwc_eff)
                    begin
                        result.cell_end = 1'b1;
                        result.row_end  = 1'b1;
                    end
                end
            endcase
            state_next.cell_is_empty    = 1'b1;
            state_next.quote_was_closed = 1'b0;
            state_next.row_has_cells    = 1'b0;
            state_next.first_unit       = 1'b1;
        end
        else if (state_reg.mode == dtp_pkg::MODE_ERROR)
        begin
            result.error_code = dtp_pkg::ERR_QUOTE;
        end
        else if (skip_bom)
        begin
            state_next.first_unit = 1'b0;
        end
        else
        begin
            state_next.first_unit = 1'b0;
            case (state_reg.mode)
                dtp_pkg::MODE_QUOTED:
                begin
                    if (!is_quote)
                    begin
                        result.data_valid        = 1'b1;
                        result.data_char         = char_code;
                        state_next.cell_is_empty = 1'b0;
                    end
                end
                dtp_pkg::MODE_QUOTE_PENDING:
                begin
                    if (is_quote)
                    begin
                        result.data_valid        = 1'b1;
                        result.data_char         = dtp_pkg::QUOTE_UNIT;
                        state_next.cell_is_empty = 1'b0;
                    end
                    else
                    begin
                        take_u = 1'b1;
                    end
                end
                dtp_pkg::MODE_CR_PENDING:
                begin
                    // Drop the LF of a CRLF
                    take_u = !is_lf;
                end
                default:
                begin
                    take_u = 1'b1;
                end
            endcase

            if (take_u)
            begin
                state_next.quote_was_closed = is_sep ? 1'b0 : qwc_eff;
                if (is_sep)
                begin
                    result.cell_end = 1'b1;
                    if (!is_delim)
                    begin
                        result.row_end = state_reg.row_has_cells || !state_reg.cell_is_empty;
                        state_next.row_has_cells = 1'b0;
                    end
                    else
                    begin
                        state_next.row_has_cells = 1'b1;
                    end
                    state_next.cell_is_empty = 1'b1;
                end
                else if (!open_quote && bad_quote)
                begin
                    result.error_code = dtp_pkg::ERR_QUOTE;
                end
                else if (!open_quote)
                begin
                    result.data_valid        = 1'b1;
                    result.data_char         = char_code;
                    state_next.cell_is_empty = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode             <= dtp_pkg::MODE_UNQUOTED;
            state_reg.cell_is_empty    <= 1'b1;
            state_reg.quote_was_closed <= 1'b0;
            state_reg.row_has_cells    <= 1'b0;
            state_reg.first_unit       <= 1'b1;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ----- tb/delimited_text_parser_tb.sv -----
`timescale 1ns / 1ps

module delimited_text_parser_tb;

    typedef logic [dtp_pkg::CHAR_W-1:0]     unit_code_t;
    typedef logic [dtp_pkg::APB_DATA_W-1:0] apb_word_t;

    typedef struct packed {
        unit_code_t code;
        logic       eot;
    } text_unit_t;

    // Tracks the parser state and holds the results each accepted request
    // should produce.
    class row_parse_scoreboard;
        dtp_pkg::mode_t   mode;
        bit               cell_empty;
        bit               quote_closed;
        bit               row_cells;
        bit               at_text_start;
        unit_code_t       delim;
        dtp_pkg::result_t expected_results[$];
        int               mismatches;

        function new();
            delim = dtp_pkg::DELIMITER_RST;
            mismatches = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            mode = dtp_pkg::MODE_UNQUOTED;
            cell_empty = 1'b1;
            quote_closed = 1'b0;
            row_cells = 1'b0;
            at_text_start = 1'b1;
        endfunction

        function void take_plain(unit_code_t c, inout dtp_pkg::result_t r);
            if (c == delim || c == dtp_pkg::LF_UNIT || c == dtp_pkg::CR_UNIT)
            begin
                r.cell_end = 1'b1;
                quote_closed = 1'b0;
                if (c != delim)
                begin
                    r.row_end = row_cells || !cell_empty;
                    row_cells = 1'b0;
                    if (c == dtp_pkg::CR_UNIT)
                        mode = dtp_pkg::MODE_CR_PENDING;
                end
                else
                begin
                    row_cells = 1'b1;
                end
                cell_empty = 1'b1;
            end
            else if (c == dtp_pkg::QUOTE_UNIT && cell_empty && !quote_closed)
            begin
                mode = dtp_pkg::MODE_QUOTED;
            end
            else if (quote_closed || c == dtp_pkg::QUOTE_UNIT)
            begin
                mode = dtp_pkg::MODE_ERROR;
                r.error_code = dtp_pkg::ERR_QUOTE;
            end
            else
            begin
                r.data_valid = 1'b1;
                r.data_char = c;
                cell_empty = 1'b0;
            end
        endfunction

        function void note_request(unit_code_t c, logic eot);
            dtp_pkg::result_t r;
            r = '0;
            if (eot)
            begin
                r.stream_done = 1'b1;
                if (mode == dtp_pkg::MODE_ERROR)
                begin
                    r.error_code = dtp_pkg::ERR_QUOTE;
                end
                else if (mode == dtp_pkg::MODE_QUOTED)
                begin
                    r.error_code = dtp_pkg::ERR_UNCLOSED;
                end
                else
                begin
                    // a quote still pending closes the cell
                    if (mode == dtp_pkg::MODE_QUOTE_PENDING)
                        quote_closed = 1'b1;
                    if (row_cells || !cell_empty || quote_closed)
                    begin
                        r.cell_end = 1'b1;
                        r.row_end = 1'b1;
                    end
                end
                clear_parse();
            end
            else if (mode == dtp_pkg::MODE_ERROR)
            begin
                r.error_code = dtp_pkg::ERR_QUOTE;
            end
            else if (at_text_start && c == dtp_pkg::BOM_UNIT)
            begin
                at_text_start = 1'b0;
            end
            else
            begin
                at_text_start = 1'b0;
                case (mode)
                    dtp_pkg::MODE_QUOTED:
                    begin
                        if (c == dtp_pkg::QUOTE_UNIT)
                        begin
                            mode = dtp_pkg::MODE_QUOTE_PENDING;
                        end
                        else
                        begin
                            r.data_valid = 1'b1;
                            r.data_char = c;
                            cell_empty = 1'b0;
                        end
                    end
                    dtp_pkg::MODE_QUOTE_PENDING:
                    begin
                        if (c == dtp_pkg::QUOTE_UNIT)
                        begin
                            r.data_valid = 1'b1;
                            r.data_char = dtp_pkg::QUOTE_UNIT;
                            cell_empty = 1'b0;
                            mode = dtp_pkg::MODE_QUOTED;
                        end
                        else
                        begin
                            mode = dtp_pkg::MODE_UNQUOTED;
                            quote_closed = 1'b1;
                            take_plain(c, r);
                        end
                    end
                    dtp_pkg::MODE_CR_PENDING:
                    begin
                        // drop the LF of a CRLF
                        mode = dtp_pkg::MODE_UNQUOTED;
                        if (c != dtp_pkg::LF_UNIT)
                            take_plain(c, r);
                    end
                    default:
                    begin
                        mode = dtp_pkg::MODE_UNQUOTED;
                        take_plain(c, r);
                    end
                endcase
            end
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(dtp_pkg::result_t got);
            dtp_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                return;
            end
            want = expected_results.pop_front();
            compare_field("data_valid", want.data_valid, got.data_valid);
            compare_field("data_char", want.data_char, got.data_char);
            compare_field("cell_end", want.cell_end, got.cell_end);
            compare_field("row_end", want.row_end, got.row_end);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("stream_done", want.stream_done, got.stream_done);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;
    logic                           s_tlast;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;
    logic [4:0]                     m_tuser;
    logic                           m_tlast;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [dtp_pkg::APB_ADDR_W-1:0] paddr;
    logic [dtp_pkg::APB_DATA_W-1:0] pwdata;
    logic [dtp_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    row_parse_scoreboard book = new();
    text_unit_t          text_q[$];
    unit_code_t          delim_cfg = dtp_pkg::DELIMITER_RST;
    bit                  burst = 1'b0;

    delimited_text_parser u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // mostly short idle stretches, now and then a long one
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            return $urandom_range(1, 3);
        else if (pick < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void put(unit_code_t c);
        text_q.push_back('{code: c, eot: 1'b0});
    endfunction

    function automatic void put_eot();
        text_q.push_back('{code: unit_code_t'($urandom_range(0, 65535)), eot: 1'b1});
    endfunction

    function automatic unit_code_t plain_char();
        unit_code_t c;
        do
        begin
            if ($urandom_range(0, 1))
                c = unit_code_t'($urandom_range(32, 126));
            else
                c = unit_code_t'($urandom_range(0, 65535));
        end
        while (c == delim_cfg || c == dtp_pkg::QUOTE_UNIT || c == dtp_pkg::CR_UNIT ||
               c == dtp_pkg::LF_UNIT);
        return c;
    endfunction

    function automatic unit_code_t noise_char();
        case ($urandom_range(0, 5))
            0: return delim_cfg;
            1: return dtp_pkg::QUOTE_UNIT;
            2: return dtp_pkg::CR_UNIT;
            3: return dtp_pkg::LF_UNIT;
            4: return dtp_pkg::BOM_UNIT;
            default: return unit_code_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void gen_cell();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind >= 2 && kind < 5)
        begin
            put(dtp_pkg::QUOTE_UNIT);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                case ($urandom_range(0, 7))
                    0: put(delim_cfg);
                    1: put(dtp_pkg::CR_UNIT);
                    2: put(dtp_pkg::LF_UNIT);
                    3:
                    begin
                        put(dtp_pkg::QUOTE_UNIT);
                        put(dtp_pkg::QUOTE_UNIT);
                    end
                    default: put(plain_char());
                endcase
            end
            put(dtp_pkg::QUOTE_UNIT);
        end
        else if (kind >= 5)
        begin
            n = $urandom_range(1, 5);
            repeat (n) put(plain_char());
        end
        if ($urandom_range(0, 19) == 0)
            put(noise_char());
    endfunction

    // one text: optional BOM, a few rows of cells, then end of text
    function automatic void gen_document();
        int rows;
        int cells;
        if ($urandom_range(0, 9) == 0)
            put(dtp_pkg::BOM_UNIT);
        rows = $urandom_range(0, 4);
        for (int r = 0; r < rows; r++)
        begin
            cells = $urandom_range(1, 4);
            for (int k = 0; k < cells; k++)
            begin
                gen_cell();
                if (k < cells - 1)
                    put(delim_cfg);
            end
            if (r < rows - 1 || $urandom_range(0, 1))
            begin
                case ($urandom_range(0, 2))
                    0: put(dtp_pkg::CR_UNIT);
                    1: put(dtp_pkg::LF_UNIT);
                    default:
                    begin
                        put(dtp_pkg::CR_UNIT);
                        put(dtp_pkg::LF_UNIT);
                    end
                endcase
                if ($urandom_range(0, 9) == 0)
                    put(dtp_pkg::LF_UNIT);
            end
        end
        if ($urandom_range(0, 11) == 0)
        begin
            put(dtp_pkg::QUOTE_UNIT);
            put(plain_char());
        end
        put_eot();
    endfunction

    task automatic drive_unit(input text_unit_t u);
        int gap;
        gap = 0;
        if (!burst && $urandom_range(0, 2) == 0)
            gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= u.code;
        s_tlast <= u.eot;
        do @(posedge clk); while (!s_tready);
        book.note_request(u.code, u.eot);
    endtask

    task automatic drive_text();
        while (text_q.size() != 0)
            drive_unit(text_q.pop_front());
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (book.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_delimiter(input unit_code_t value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= dtp_pkg::REG_DELIMITER;
        pwdata <= apb_word_t'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        delim_cfg = value;
        book.delim = value;
    endtask

    // receiver: random stalls plus two long hold-offs to back up the input
    initial
    begin
        int stall;
        int seen;
        dtp_pkg::result_t got;
        stall = 0;
        seen = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.data_valid = m_tuser[0];
                got.data_char = m_tdata;
                got.cell_end = m_tuser[1];
                got.row_end = m_tuser[2];
                got.error_code = m_tuser[4:3];
                got.stream_done = m_tlast;
                book.check_result(got);
                seen++;
                if (seen == 300 || seen == 1100)
                    stall = 200;
            end
            if (stall == 0 && !burst && $urandom_range(0, 2) == 0)
                stall = gap_len();
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        unit_code_t delim_plan[9];
        int start_len;
        delim_plan = '{16'h0009, 16'h003b, 16'h0000, 16'hffff, dtp_pkg::QUOTE_UNIT,
                       dtp_pkg::CR_UNIT, dtp_pkg::LF_UNIT, 16'h0000,
                       dtp_pkg::DELIMITER_RST};
        delim_plan[7] = unit_code_t'($urandom_range(0, 65535));
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leading BOM, plain and quoted cells, doubled quote, CRLF, empty row
        put(dtp_pkg::BOM_UNIT);
        put(16'h0061);
        put(delim_cfg);
        put(dtp_pkg::QUOTE_UNIT);
        put(delim_cfg);
        put(dtp_pkg::QUOTE_UNIT);
        put(dtp_pkg::QUOTE_UNIT);
        put(dtp_pkg::QUOTE_UNIT);
        put(dtp_pkg::CR_UNIT);
        put(dtp_pkg::LF_UNIT);
        put(dtp_pkg::LF_UNIT);
        put(16'hffff);
        put(16'h0000);
        // quote in a nonempty cell, then sticky error
        put(dtp_pkg::QUOTE_UNIT);
        put(16'h007a);
        put_eot();
        // unclosed quote at end
        put(dtp_pkg::QUOTE_UNIT);
        put(16'h0071);
        put_eot();
        // quoted empty cell closed by the end of text
        put(dtp_pkg::QUOTE_UNIT);
        put(dtp_pkg::QUOTE_UNIT);
        put_eot();
        // BOM only skipped once; lone CR; char after a closing quote
        put(dtp_pkg::BOM_UNIT);
        put(dtp_pkg::BOM_UNIT);
        put(dtp_pkg::CR_UNIT);
        put(dtp_pkg::QUOTE_UNIT);
        put(dtp_pkg::QUOTE_UNIT);
        put(16'h0063);
        put_eot();
        drive_text();
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            write_delimiter(delim_plan[phase]);
            burst = (phase % 3 == 1);
            start_len = 0;
            while (start_len < 180)
            begin
                gen_document();
                start_len = text_q.size();
            end
            drive_text();
            drain();
        end
        burst = 1'b0;

        while (book.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (book.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
